[design/ptr_pkg.sv]
// Shared types and constants of the proportional text rasterizer.
package ptr_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_CHAR  = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 2;
    localparam int         CFG_DATA_W      = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_COLUMN  = 2'd1;
    localparam logic [5:0] LINE_HEIGHT_RST = 6'd8;
    localparam logic [7:0] TAB_COLUMN_RST  = 8'd48;

    // Character classes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] LOWER_FIRST = 8'h61;
    localparam logic [7:0] LOWER_LAST  = 8'h7A;
    localparam logic [7:0] CASE_SHIFT  = 8'd32;
    localparam logic [7:0] ICON_FIRST  = 8'h80;
    localparam logic [7:0] ICON_END    = 8'h90;
    localparam logic [7:0] PRINT_FIRST = 8'd32;
    localparam logic [7:0] PRINT_LAST  = 8'd126;

    localparam logic [3:0] SCALE_MIN = 4'd1;
    localparam logic [3:0] SCALE_MAX = 4'd8;
    localparam int         TAB_STEP  = 8;

    // Glyph geometry
    localparam int         ROW_BITS   = 56;
    localparam int         GLYPH_W    = 60;
    localparam logic [2:0] ROW_LAST   = 3'd6;
    localparam logic [2:0] COL_LAST   = 3'd7;
    localparam int         PROD_W     = 11;
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_BEGIN,
        OP_NEWLINE,
        OP_TAB,
        OP_GLYPH
    } op_t;

    // One classified item on its way from the front to the back
    typedef struct packed {
        op_t                 op;
        logic [7:0]          slot;
        logic [15:0]         origin_x;
        logic [15:0]         origin_y;
        logic [3:0]          scale;
        logic [7:0]          color;
        logic [3:0]          width;
        logic [ROW_BITS-1:0] rows;
    } cmd_t;

endpackage

[design/ptr_ram.sv]
// Generic single-port-write, registered-read RAM.
module ptr_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[design/ptr_front.sv]
// Front end: decodes an input item into a classified command.
module ptr_front #(
    parameter int GLYPH_SLOTS = 144
) (
    input  logic [1:0]          func,
    input  logic [7:0]          char_code,
    input  logic [15:0]         origin_x,
    input  logic [15:0]         origin_y,
    input  logic [3:0]          scale,
    input  logic [7:0]          color,
    input  logic [3:0]          glyph_width,
    input  logic [55:0]         glyph_rows,
    output ptr_pkg::cmd_t       cmd
);

    import ptr_pkg::*;

    logic [7:0] upper;
    logic [7:0] char_slot;
    logic [3:0] scale_clamped;

    // Fold lower case onto upper case, then pick icon, printable or '?' slot
    always_comb
    begin
        upper = char_code;
        if (char_code >= LOWER_FIRST && char_code <= LOWER_LAST)
        begin
            upper = char_code - CASE_SHIFT;
        end
        if (upper >= ICON_FIRST && upper < ICON_END)
        begin
            char_slot = upper;
        end
        else if (upper < PRINT_FIRST || upper > PRINT_LAST)
        begin
            char_slot = CH_QMARK;
        end
        else
        begin
            char_slot = upper;
        end
    end

    always_comb
    begin
        if (scale < SCALE_MIN)
        begin
            scale_clamped = SCALE_MIN;
        end
        else if (scale > SCALE_MAX)
        begin
            scale_clamped = SCALE_MAX;
        end
        else
        begin
            scale_clamped = scale;
        end
    end

    always_comb
    begin
        cmd.slot     = char_code;
        cmd.origin_x = origin_x;
        cmd.origin_y = origin_y;
        cmd.scale    = scale_clamped;
        cmd.color    = color;
        cmd.width    = glyph_width;
        cmd.rows     = glyph_rows;
        unique case (func)
            FUNC_LOAD:
            begin
                // Drop loads aimed past the end of the store
                cmd.op = (32'(char_code) < GLYPH_SLOTS) ? OP_LOAD : OP_NOP;
            end
            FUNC_BEGIN:
            begin
                cmd.op = OP_BEGIN;
            end
            FUNC_CHAR:
            begin
                if (char_code == CH_NEWLINE)
                begin
                    cmd.op = OP_NEWLINE;
                end
                else if (char_code == CH_TAB)
                begin
                    cmd.op = OP_TAB;
                end
                else
                begin
                    cmd.op   = OP_GLYPH;
                    cmd.slot = char_slot;
                end
            end
            default:
            begin
                cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

[design/ptr_queue.sv]
// Short command queue between front and back.
module ptr_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ptr_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    output ptr_pkg::cmd_t pop_cmd,
    input  logic          pop
);

    import ptr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/ptr_back.sv]
// Back end: executes commands, owns the glyph store, pen state and result register.
module ptr_back #(
    parameter int GLYPH_SLOTS = 144,
    parameter int COORD_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ptr_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    input  logic [5:0]         line_height,
    input  logic [7:0]         tab_column,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_pixel,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [3:0]         pixel_size,
    output logic [7:0]         pixel_color,
    output logic signed [15:0] pen_x,
    output logic               last
);

    import ptr_pkg::*;

    localparam int SLOT_W = $clog2(GLYPH_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_APPLY,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic                   hit_reg;
    logic [GLYPH_SLOTS-1:0] valid_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ROW_BITS-1:0]    glyph_rows_reg;
    logic [3:0]             glyph_w_reg;
    logic [COORD_BITS-1:0]  pen_h_reg;
    logic [COORD_BITS-1:0]  pen_v_reg;
    logic [COORD_BITS-1:0]  line_start_reg;
    logic [COORD_BITS-1:0]  base_x_reg;
    logic [COORD_BITS-1:0]  col_x_reg;
    logic [COORD_BITS-1:0]  row_y_reg;
    logic [3:0]             scale_reg;
    logic [7:0]             color_reg;
    logic [2:0]             row_reg;
    logic [2:0]             col_reg;

    logic [GLYPH_W-1:0]     rdata;
    logic [GLYPH_W-1:0]     g_data;
    logic                   ram_we;
    logic [7:0]             mul_a;
    logic [PROD_W-1:0]      product;
    logic [COORD_BITS-1:0]  offset;
    logic                   tab_to_stop;
    logic                   lit;
    logic                   can_load;
    logic                   result_load;

    function automatic logic [COORD_BITS-1:0] from16(input logic [15:0] v);
        return COORD_BITS'(32'($signed(v)));
    endfunction

    function automatic logic [15:0] to16(input logic [COORD_BITS-1:0] v);
        return 16'(32'($signed(v)));
    endfunction

    assign ram_we = (state_reg == ST_IDLE) && q_valid && (q_cmd.op == OP_LOAD);

    ptr_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_SLOTS)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_cmd.slot[SLOT_W-1:0]),
        .wdata ({q_cmd.width, q_cmd.rows}),
        .raddr (q_cmd.slot[SLOT_W-1:0]),
        .rdata (rdata)
    );

    // A slot never loaded reads as an empty glyph
    assign g_data   = hit_reg ? rdata : '0;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign can_load = !out_valid || out_ready;
    assign lit      = glyph_rows_reg[{row_reg, col_reg}] && ({1'b0, col_reg} < glyph_w_reg);
    assign offset   = pen_h_reg - line_start_reg;
    assign tab_to_stop = offset[COORD_BITS-1] || (32'(offset) < 32'(prod_reg));
    // A new result enters the output register this cycle
    assign result_load = can_load
                         && (((state_reg == ST_SCAN) && lit) || (state_reg == ST_DONE));

    always_comb
    begin
        case (op_reg)
            OP_NEWLINE: mul_a = 8'(line_height);
            OP_TAB:     mul_a = tab_column;
            OP_GLYPH:   mul_a = 8'(5'(g_data[GLYPH_W-1:ROW_BITS]) + 5'd1);
            default:    mul_a = '0;
        endcase
        product = PROD_W'(12'(mul_a) * 12'(scale_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_NOP;
            hit_reg        <= 1'b0;
            valid_reg      <= '0;
            prod_reg       <= '0;
            glyph_rows_reg <= '0;
            glyph_w_reg    <= '0;
            pen_h_reg      <= '0;
            pen_v_reg      <= '0;
            line_start_reg <= '0;
            base_x_reg     <= '0;
            col_x_reg      <= '0;
            row_y_reg      <= '0;
            scale_reg      <= SCALE_MIN;
            color_reg      <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            out_valid      <= 1'b0;
            is_pixel       <= 1'b0;
            pixel_x        <= '0;
            pixel_y        <= '0;
            pixel_size     <= '0;
            pixel_color    <= '0;
            pen_x          <= '0;
            last           <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !result_load)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg  <= q_cmd.op;
                        hit_reg <= valid_reg[q_cmd.slot[SLOT_W-1:0]];
                        case (q_cmd.op) inside
                            OP_LOAD:
                            begin
                                valid_reg[q_cmd.slot[SLOT_W-1:0]] <= 1'b1;
                                state_reg <= ST_DONE;
                            end
                            OP_BEGIN:
                            begin
                                pen_h_reg      <= from16(q_cmd.origin_x);
                                line_start_reg <= from16(q_cmd.origin_x);
                                pen_v_reg      <= from16(q_cmd.origin_y);
                                scale_reg      <= q_cmd.scale;
                                color_reg      <= q_cmd.color;
                                state_reg      <= ST_DONE;
                            end
                            OP_NEWLINE, OP_TAB, OP_GLYPH:
                            begin
                                state_reg <= ST_MUL;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    prod_reg       <= product;
                    glyph_rows_reg <= g_data[ROW_BITS-1:0];
                    glyph_w_reg    <= g_data[GLYPH_W-1:ROW_BITS];
                    state_reg      <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    case (op_reg)
                        OP_NEWLINE:
                        begin
                            pen_h_reg <= line_start_reg;
                            pen_v_reg <= pen_v_reg + COORD_BITS'(prod_reg);
                            state_reg <= ST_DONE;
                        end
                        OP_TAB:
                        begin
                            if (tab_to_stop)
                            begin
                                pen_h_reg <= line_start_reg + COORD_BITS'(prod_reg);
                            end
                            else
                            begin
                                pen_h_reg <= pen_h_reg
                                           + COORD_BITS'(32'(TAB_STEP) * 32'(scale_reg));
                            end
                            state_reg <= ST_DONE;
                        end
                        OP_GLYPH:
                        begin
                            pen_h_reg  <= pen_h_reg + COORD_BITS'(prod_reg);
                            base_x_reg <= pen_h_reg;
                            col_x_reg  <= pen_h_reg;
                            row_y_reg  <= pen_v_reg;
                            row_reg    <= '0;
                            col_reg    <= '0;
                            state_reg  <= ST_SCAN;
                        end
                        default:
                        begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_SCAN:
                begin
                    // Hold on a lit pixel while the result register is full
                    if (!lit || can_load)
                    begin
                        if (lit)
                        begin
                            out_valid   <= 1'b1;
                            is_pixel    <= 1'b1;
                            pixel_x     <= to16(col_x_reg);
                            pixel_y     <= to16(row_y_reg);
                            pixel_size  <= scale_reg;
                            pixel_color <= color_reg;
                            pen_x       <= to16(pen_h_reg);
                            last        <= 1'b0;
                        end
                        if (col_reg == COL_LAST)
                        begin
                            col_reg   <= '0;
                            col_x_reg <= base_x_reg;
                            row_y_reg <= row_y_reg + COORD_BITS'(scale_reg);
                            if (row_reg == ROW_LAST)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                row_reg <= row_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            col_reg   <= col_reg + 3'd1;
                            col_x_reg <= col_x_reg + COORD_BITS'(scale_reg);
                        end
                    end
                end
                ST_DONE:
                begin
                    if (can_load)
                    begin
                        out_valid   <= 1'b1;
                        is_pixel    <= 1'b0;
                        pixel_x     <= '0;
                        pixel_y     <= '0;
                        pixel_size  <= '0;
                        pixel_color <= '0;
                        pen_x       <= to16(pen_h_reg);
                        last        <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/proportional_text_rasterizer.sv]
// Top level of the proportional bitmap text rasterizer.
//
// Input channel (in_valid/in_ready): one item per handshake. func selects
// load of a glyph slot, begin of a string (origin, scale, color) or one
// character. Items pass a decoder into a two-entry command queue, so the
// input side keeps taking items while the back end draws.
// Output channel (out_valid/out_ready): every item yields its pixel squares,
// then one completion result with last set; all results carry the pen
// position after the item.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 line_height,
// index 1 tab_column; other indexes are ignored.
// Throughput: the back end works one item at a time. Loads, begins and unknown
// functions go straight to the completion result; newline, tab and a glyph
// first pass a multiply and an apply step. A glyph's 7x8 pixel grid is then
// scanned one cell per cycle whether lit or not, holding on a lit pixel while
// the result register is full. The next item is taken once the completion is out.
// Reset clears pen, line start, color, scale (to one) and the per-slot valid
// bits, so unloaded slots read as empty glyphs; line_height returns to 8 and
// tab_column to 48.
// A stalled receiver freezes the scan on the next lit pixel; the queue
// fills and then in_ready drops.
module proportional_text_rasterizer #(
    parameter int GLYPH_SLOTS = 144,
    parameter int COORD_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Item input
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic [7:0]                         char_code,
    input  logic signed [15:0]                 origin_x,
    input  logic signed [15:0]                 origin_y,
    input  logic [3:0]                         scale,
    input  logic [7:0]                         color,
    input  logic [3:0]                         glyph_width,
    input  logic [55:0]                        glyph_rows,
    // Result output
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               is_pixel,
    output logic signed [15:0]                 pixel_x,
    output logic signed [15:0]                 pixel_y,
    output logic [3:0]                         pixel_size,
    output logic [7:0]                         pixel_color,
    output logic signed [15:0]                 pen_x,
    output logic                               last,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import ptr_pkg::*;

    cmd_t       front_cmd;
    cmd_t       q_cmd;
    logic       q_valid;
    logic       q_pop;
    logic [5:0] line_height_reg;
    logic [7:0] tab_column_reg;

    // Config writes must land only while idle; the user must ensure it, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_height_reg <= LINE_HEIGHT_RST;
            tab_column_reg  <= TAB_COLUMN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LINE_HEIGHT: line_height_reg <= cfg_data[5:0];
                REG_TAB_COLUMN:  tab_column_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Classify the incoming item
    ptr_front #(
        .GLYPH_SLOTS (GLYPH_SLOTS)
    ) u_front (
        .func        (func),
        .char_code   (char_code),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .scale       (scale),
        .color       (color),
        .glyph_width (glyph_width),
        .glyph_rows  (glyph_rows),
        .cmd         (front_cmd)
    );

    // Decouple acceptance from drawing
    ptr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop        (q_pop)
    );

    // Execute commands and drive the result register
    ptr_back #(
        .GLYPH_SLOTS (GLYPH_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .line_height (line_height_reg),
        .tab_column  (tab_column_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_pixel    (is_pixel),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_size  (pixel_size),
        .pixel_color (pixel_color),
        .pen_x       (pen_x),
        .last        (last)
    );

    // A pixel square never closes an item and always has a legal size
    a_pixel_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_pixel |-> !last && pixel_size >= SCALE_MIN && pixel_size <= SCALE_MAX)
        else $error("pixel result with last set or bad size");

    // The completion result carries no square
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !is_pixel && pixel_x == 16'sd0 && pixel_y == 16'sd0
                              && pixel_size == 4'd0 && pixel_color == 8'd0)
        else $error("completion result carries pixel fields");

    // Back-to-back squares share the scale, color and pen position of one glyph
    a_pixel_attr_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_pixel ##1 out_valid && is_pixel
        |-> $stable(pixel_size) && $stable(pixel_color) && $stable(pen_x))
        else $error("pixel attributes changed inside a glyph");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the proportional text rasterizer: directed and random items.
module tb_top;
    import ptr_pkg::*;

    localparam int                   SLOT_COUNT   = 144;
    localparam logic [1:0]           FUNC_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;
    localparam int                   CYCLE_LIMIT  = 1_000_000;
    localparam int                   DRAIN_SETTLE = 8;
    localparam int                   END_SETTLE   = 80;
    localparam int                   MAX_REPORTS  = 10;
    localparam logic [55:0]          ROWS_FULL    = {56{1'b1}};

    // One input item as the sender sees it
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  code;
        logic [15:0] org_x;
        logic [15:0] org_y;
        logic [3:0]  scale_req;
        logic [7:0]  color_req;
        logic [3:0]  width;
        logic [55:0] rows;
    } text_item_t;

    // One result: a square to fill or the completion of an item
    typedef struct packed {
        logic        is_pixel;
        logic [15:0] x;
        logic [15:0] y;
        logic [3:0]  size;
        logic [7:0]  color;
        logic [15:0] pen;
        logic        last;
    } draw_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  func;
    logic [7:0]                  char_code;
    logic signed [15:0]          origin_x;
    logic signed [15:0]          origin_y;
    logic [3:0]                  scale;
    logic [7:0]                  color;
    logic [3:0]                  glyph_width;
    logic [55:0]                 glyph_rows;
    logic                        out_valid;
    logic                        out_ready;
    logic                        is_pixel;
    logic signed [15:0]          pixel_x;
    logic signed [15:0]          pixel_y;
    logic [3:0]                  pixel_size;
    logic [7:0]                  pixel_color;
    logic signed [15:0]          pen_x;
    logic                        last;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    // Predictor state: glyph store, pen, line start, active style, registers
    logic [59:0]  font_store [SLOT_COUNT];
    logic [15:0]  pen_h;
    logic [15:0]  pen_v;
    logic [15:0]  line_left;
    logic [3:0]   cur_scale;
    logic [7:0]   cur_color;
    logic [5:0]   line_height_reg;
    logic [7:0]   tab_column_reg;

    draw_result_t expected_draws [$];
    int           mismatches;
    int unsigned  cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    proportional_text_rasterizer DUT (.*);

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: stall at random, decided at each falling edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Abort on a hang
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("proportional_text_rasterizer test failed");
            $finish;
        end
    end

    // Map a character byte onto the glyph slot that draws it
    function automatic logic [7:0] glyph_slot(input logic [7:0] code);
        logic [7:0] s;
        s = code;
        if (s >= LOWER_FIRST && s <= LOWER_LAST)
            s = s - CASE_SHIFT;
        if (s >= ICON_FIRST && s < ICON_END)
            return s;
        if (s < PRINT_FIRST || s > PRINT_LAST)
            return CH_QMARK;
        return s;
    endfunction

    // Random content in every field; callers overwrite what matters
    function automatic text_item_t noise_item();
        text_item_t it;
        it.func      = 2'($urandom_range(0, 3));
        it.code      = 8'($urandom);
        it.org_x     = 16'($urandom);
        it.org_y     = 16'($urandom);
        it.scale_req = 4'($urandom);
        it.color_req = 8'($urandom);
        it.width     = 4'($urandom);
        it.rows      = {24'($urandom), 32'($urandom)};
        return it;
    endfunction

    function automatic text_item_t char_item(input logic [7:0] code);
        text_item_t it;
        it      = noise_item();
        it.func = FUNC_CHAR;
        it.code = code;
        return it;
    endfunction

    function automatic text_item_t begin_item(input logic [15:0] x, input logic [15:0] y,
                                              input logic [3:0] s, input logic [7:0] c);
        text_item_t it;
        it           = noise_item();
        it.func      = FUNC_BEGIN;
        it.org_x     = x;
        it.org_y     = y;
        it.scale_req = s;
        it.color_req = c;
        return it;
    endfunction

    function automatic text_item_t load_item(input logic [7:0] slot, input logic [3:0] w,
                                             input logic [55:0] rows);
        text_item_t it;
        it       = noise_item();
        it.func  = FUNC_LOAD;
        it.code  = slot;
        it.width = w;
        it.rows  = rows;
        return it;
    endfunction

    task automatic reset_predictor();
        foreach (font_store[i])
            font_store[i] = '0;
        pen_h           = '0;
        pen_v           = '0;
        line_left       = '0;
        cur_scale       = SCALE_MIN;
        cur_color       = '0;
        line_height_reg = LINE_HEIGHT_RST;
        tab_column_reg  = TAB_COLUMN_RST;
    endtask

    // Update the predicted state for one accepted item and queue its results
    task automatic rasterize_item(input text_item_t it);
        logic [59:0]  glyph;
        logic [3:0]   w;
        int           cols;
        logic [15:0]  stop;
        logic [15:0]  off;
        logic [7:0]   row_bits;
        draw_result_t sq;
        draw_result_t squares [$];
        squares = {};
        case (it.func)
            FUNC_LOAD:
                if (it.code < SLOT_COUNT)
                    font_store[it.code] = {it.width, it.rows};
            FUNC_BEGIN:
            begin
                // Clamp scale into 1..8
                if (it.scale_req < SCALE_MIN)
                    cur_scale = SCALE_MIN;
                else if (it.scale_req > SCALE_MAX)
                    cur_scale = SCALE_MAX;
                else
                    cur_scale = it.scale_req;
                pen_h     = it.org_x;
                line_left = it.org_x;
                pen_v     = it.org_y;
                cur_color = it.color_req;
            end
            FUNC_CHAR:
            begin
                if (it.code == CH_NEWLINE)
                begin
                    pen_h = line_left;
                    pen_v = pen_v + line_height_reg * cur_scale;
                end
                else if (it.code == CH_TAB)
                begin
                    // Jump to the tab stop unless already at or past it
                    stop = tab_column_reg * cur_scale;
                    off  = pen_h - line_left;
                    if (off[15] || off < stop)
                        pen_h = line_left + stop;
                    else
                        pen_h = 16'(pen_h + TAB_STEP * cur_scale);
                end
                else
                begin
                    glyph = font_store[glyph_slot(it.code)];
                    w     = glyph[59:56];
                    cols  = (w > 4'd8) ? 8 : int'(w);
                    // Scan row 0 first, columns ascending
                    for (int r = 0; r < 7; r++)
                    begin
                        row_bits = glyph[8*r +: 8];
                        for (int c = 0; c < cols; c++)
                        begin
                            if (row_bits[c])
                            begin
                                sq          = '0;
                                sq.is_pixel = 1'b1;
                                sq.x        = 16'(pen_h + c * cur_scale);
                                sq.y        = 16'(pen_v + r * cur_scale);
                                sq.size     = cur_scale;
                                sq.color    = cur_color;
                                squares.push_back(sq);
                            end
                        end
                    end
                    pen_h = 16'(pen_h + (w + 1) * cur_scale);
                end
            end
            default: ;
        endcase
        // Every result carries the pen after the item; the completion closes it
        foreach (squares[i])
        begin
            squares[i].pen = pen_h;
            expected_draws.push_back(squares[i]);
        end
        sq      = '0;
        sq.pen  = pen_h;
        sq.last = 1'b1;
        expected_draws.push_back(sq);
    endtask

    // Drive one item at a falling edge and hold it until accepted
    task automatic send_item(input text_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        func        = it.func;
        char_code   = it.code;
        origin_x    = it.org_x;
        origin_y    = it.org_y;
        scale       = it.scale_req;
        color       = it.color_req;
        glyph_width = it.width;
        glyph_rows  = it.rows;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        rasterize_item(it);
    endtask

    // Drop valid and wait until every queued result has come out
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_LINE_HEIGHT)
            line_height_reg = data[5:0];
        else if (idx == REG_TAB_COLUMN)
            tab_column_reg = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Glyph loads, every glyph-drawing character class and an unknown function at the reset registers
    task automatic test_character_classes();
        send_item(load_item("A", 4'd5, 56'h11_11_1F_11_11_0A_04));
        send_item(load_item(CH_QMARK, 4'd8, ROWS_FULL));       // fullest glyph
        send_item(load_item(ICON_FIRST, 4'd3, 56'h05_02_05_00_07_00_02));
        send_item(load_item(8'h8F, 4'd1, 56'h01_00_01_00_01_00_01));
        send_item(load_item("B", 4'd15, ROWS_FULL));           // wider than the grid
        send_item(load_item(" ", 4'd0, ROWS_FULL));            // zero width, no pixels
        send_item(load_item(8'd200, 4'd8, ROWS_FULL));         // slot beyond the store
        send_item(begin_item(16'd0, 16'd0, 4'd0, 8'hA5));      // scale 0 reads as 1
        send_item(char_item("a"));
        send_item(char_item("A"));
        send_item(char_item(ICON_FIRST));
        send_item(char_item(8'h8F));
        send_item(char_item(8'h00));
        send_item(char_item(8'hFF));
        send_item(char_item(8'h7F));
        send_item(char_item(" "));
        send_item(char_item("B"));
        send_item(char_item(8'h7E));
        send_item(char_item(8'd200));
        begin
            text_item_t odd;
            odd      = noise_item();
            odd.func = FUNC_NONE;
            send_item(odd);
        end
    endtask

    // Pen motion at the coordinate extremes: wrap in x and y, tab both ways
    task automatic test_pen_motion();
        send_item(begin_item(16'h7FFF, 16'h8000, 4'd15, 8'hFF));
        send_item(char_item("A"));
        send_item(char_item(CH_TAB));
        send_item(char_item(CH_TAB));
        send_item(char_item(CH_NEWLINE));
        send_item(begin_item(16'h8000, 16'h7FF0, 4'd8, 8'h00));
        send_item(char_item(CH_NEWLINE));
        send_item(char_item("?"));
    endtask

    // Register extremes, written only with the block idle
    task automatic test_register_extremes();
        wait_for_drain();
        write_register(REG_LINE_HEIGHT, 8'd0);
        write_register(REG_TAB_COLUMN, 8'd0);
        send_item(begin_item(16'h0100, 16'hFF00, 4'd3, 8'h5A));
        send_item(char_item(CH_NEWLINE));
        send_item(char_item(CH_TAB));
        send_item(char_item("A"));
        wait_for_drain();
        write_register(REG_LINE_HEIGHT, 8'hFF);
        write_register(REG_TAB_COLUMN, 8'hFF);
        write_register(REG_SPARE_2, 8'h01);    // unused indexes: no effect
        write_register(REG_SPARE_3, 8'h01);
        send_item(begin_item(16'hFC00, 16'h0010, 4'd8, 8'h3C));
        send_item(char_item(CH_TAB));
        send_item(char_item(CH_TAB));
        send_item(char_item(CH_NEWLINE));
        send_item(char_item("A"));
        wait_for_drain();
        write_register(REG_LINE_HEIGHT, 8'd1);
        write_register(REG_TAB_COLUMN, TAB_COLUMN_RST);
    endtask

    // Mostly begin-then-text strings, with reloads and some noise mixed in
    task automatic test_random_text(input int count);
        int          pick;
        int          sub;
        logic [7:0]  slot;
        logic [3:0]  w;
        logic [3:0]  s;
        text_item_t  it;
        wait_for_drain();
        write_register(REG_LINE_HEIGHT, 8'($urandom_range(0, 63)));
        write_register(REG_TAB_COLUMN, 8'($urandom_range(0, 255)));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            sub  = $urandom_range(0, 99);
            if (pick < 15)
            begin
                if (sub < 60)
                    slot = 8'("A" + $urandom_range(0, 9));
                else if (sub < 75)
                    slot = 8'(ICON_FIRST + $urandom_range(0, 15));
                else if (sub < 80)
                    slot = CH_QMARK;
                else
                    slot = 8'($urandom_range(0, 255));
                w = ($urandom_range(0, 9) < 9) ? 4'($urandom_range(0, 8))
                                               : 4'($urandom_range(9, 15));
                it = load_item(slot, w, {24'($urandom), 32'($urandom)});
            end
            else if (pick < 27)
            begin
                s = (sub < 80) ? 4'($urandom_range(1, 4)) : 4'($urandom);
                it = begin_item(16'($urandom), 16'($urandom), s, 8'($urandom));
            end
            else if (pick < 30)
            begin
                it      = noise_item();
                it.func = FUNC_NONE;
            end
            else
            begin
                if (sub < 45)
                    slot = 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 9));
                else if (sub < 55)
                    slot = CH_NEWLINE;
                else if (sub < 63)
                    slot = CH_TAB;
                else if (sub < 73)
                    slot = 8'(ICON_FIRST + $urandom_range(0, 15));
                else if (sub < 85)
                    slot = 8'($urandom_range(PRINT_FIRST, PRINT_LAST));
                else
                    slot = 8'($urandom_range(0, 255));
                it = char_item(slot);
            end
            send_item(it);
        end
    endtask

    // Compare each result against the oldest queued expectation
    always @(posedge clk)
    begin : check_results
        draw_result_t seen;
        draw_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {is_pixel, pixel_x, pixel_y, pixel_size, pixel_color, pen_x, last};
            if (expected_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result pix=%0b x=%h y=%h size=%0d color=%h pen=%h last=%0b",
                             seen.is_pixel, seen.x, seen.y, seen.size, seen.color,
                             seen.pen, seen.last);
            end
            else
            begin
                want = expected_draws.pop_front();
                if (seen.is_pixel !== want.is_pixel || seen.x !== want.x ||
                    seen.y !== want.y || seen.size !== want.size ||
                    seen.color !== want.color || seen.pen !== want.pen ||
                    seen.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch exp pix=%0b x=%h y=%h size=%0d color=%h pen=%h last=%0b",
                                 want.is_pixel, want.x, want.y, want.size, want.color,
                                 want.pen, want.last);
                        $display("         got pix=%0b x=%h y=%h size=%0d color=%h pen=%h last=%0b",
                                 seen.is_pixel, seen.x, seen.y, seen.size, seen.color,
                                 seen.pen, seen.last);
                    end
                end
            end
        end
    end

    initial
    begin
        // Hold every input at a known value from time zero
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_LOAD;
        char_code     = '0;
        origin_x      = '0;
        origin_y      = '0;
        scale         = '0;
        color         = '0;
        glyph_width   = '0;
        glyph_rows    = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_LINE_HEIGHT;
        cfg_data      = '0;
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 30;
        recv_idle_pct = 82;
        reset_predictor();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles lightly, receiver stalls heavily
        test_character_classes();
        test_pen_motion();
        test_register_extremes();
        test_random_text(70);

        // Swap the pressure
        send_idle_pct = 82;
        recv_idle_pct = 30;
        test_random_text(70);

        // Full speed on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(70);

        // Drain, then allow a glyph's worth of cycles for stray results
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0 && expected_draws.size() == 0)
            $display("proportional_text_rasterizer test passed");
        else
            $display("proportional_text_rasterizer test failed");
        $finish;
    end

endmodule
